// ===== rtl/tfa_pkg.sv =====
// shared types and constants for the two-resource fit allocator
// no dependencies
`default_nettype none

package tfa_pkg;

    localparam int TAG_W       = 8;
    localparam int NEED_C_W    = 5;
    localparam int NEED_M_W    = 7;
    localparam int IDX_OUT_W   = 7;
    localparam int CORES_OUT_W = 5;
    localparam int MEM_OUT_W   = 7;
    localparam int MODE_W      = 2;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/two_resource_fit_allocator.sv =====
// two-resource fit allocator: scans one node per cycle through the single memory
// read port; a new request is taken only in idle, after the result of the last
// one has been accepted downstream
// after reset a clearing pass loads every node with full resources; requests
// wait until it ends, configuration writes are taken always
// depends on tfa_pkg, tfa_node_mem, tfa_fit_unit
`default_nettype none

module two_resource_fit_allocator
    import tfa_pkg::*;
#(
    parameter int NODE_COUNT      = 128,
    parameter int CORES_PER_NODE  = 24,
    parameter int MEMORY_PER_NODE = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [MODE_W-1:0]     i_cfg_wdata,   // fit_mode
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // job_tag, cores_needed, memory_needed
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // job_tag_out, placed, node_index,
                                                      // cores_left, memory_left
);

    localparam int AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int IXW = $clog2(NODE_COUNT + 1);
    localparam int CWD = $clog2(CORES_PER_NODE + 1);
    localparam int MWD = $clog2(MEMORY_PER_NODE + 1);
    localparam int CXW = (CWD > NEED_C_W) ? CWD : NEED_C_W;
    localparam int MXW = (MWD > NEED_M_W) ? MWD : NEED_M_W;
    localparam int LW  = ((CXW > MXW) ? CXW : MXW) + 1;
    localparam int DW  = CWD + MWD;

    t_state r_state, n_state;

    logic [IXW-1:0]      r_idx, n_idx;
    logic                r_ev_vld, n_ev_vld;
    logic [AW-1:0]       r_ev_idx, n_ev_idx;
    logic [MODE_W-1:0]   r_fit_mode;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic [NEED_C_W-1:0] r_need_c, n_need_c;
    logic [NEED_M_W-1:0] r_need_m, n_need_m;
    logic                r_found, n_found;
    logic [AW-1:0]       r_pick, n_pick;
    logic [LW-1:0]       r_pick_left, n_pick_left;
    logic [CWD-1:0]      r_pick_c, n_pick_c;
    logic [MWD-1:0]      r_pick_m, n_pick_m;

    logic [TAG_W-1:0]       r_out_tag, n_out_tag;
    logic                   r_out_placed, n_out_placed;
    logic [IDX_OUT_W-1:0]   r_out_idx, n_out_idx;
    logic [CORES_OUT_W-1:0] r_out_cores, n_out_cores;
    logic [MEM_OUT_W-1:0]   r_out_mem, n_out_mem;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [DW-1:0] mem_rdata;

    logic           fit_take;
    logic [LW-1:0]  fit_left;
    logic [CWD-1:0] fit_cores_rem;
    logic [MWD-1:0] fit_mem_rem;

    logic [AW+IDX_OUT_W-1:0]    idx_ext;
    logic [CWD+CORES_OUT_W-1:0] cores_ext;
    logic [MWD+MEM_OUT_W-1:0]   mem_ext;

    tfa_node_mem #(
        .DEPTH(NODE_COUNT),
        .AW   (AW),
        .DW   (DW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(mem_rdata)
    );

    tfa_fit_unit #(
        .CWD(CWD),
        .MWD(MWD),
        .LW (LW)
    ) u_fit (
        .i_mode     (r_fit_mode),
        .i_found    (r_found),
        .i_pick_left(r_pick_left),
        .i_cores    (mem_rdata[CWD-1:0]),
        .i_mem      (mem_rdata[DW-1:CWD]),
        .i_need_c   (r_need_c),
        .i_need_m   (r_need_m),
        .o_take     (fit_take),
        .o_left     (fit_left),
        .o_cores_rem(fit_cores_rem),
        .o_mem_rem  (fit_mem_rem)
    );

    assign idx_ext   = {{IDX_OUT_W{1'b0}}, r_pick};
    assign cores_ext = {{CORES_OUT_W{1'b0}}, r_pick_c};
    assign mem_ext   = {{MEM_OUT_W{1'b0}}, r_pick_m};

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_ev_vld     = 1'b0;
        n_ev_idx     = r_idx[AW-1:0];
        n_tag        = r_tag;
        n_need_c     = r_need_c;
        n_need_m     = r_need_m;
        n_found      = r_found;
        n_pick       = r_pick;
        n_pick_left  = r_pick_left;
        n_pick_c     = r_pick_c;
        n_pick_m     = r_pick_m;
        n_out_tag    = r_out_tag;
        n_out_placed = r_out_placed;
        n_out_idx    = r_out_idx;
        n_out_cores  = r_out_cores;
        n_out_mem    = r_out_mem;
        mem_we       = 1'b0;
        mem_waddr    = r_idx[AW-1:0];
        mem_wdata    = {MWD'(MEMORY_PER_NODE), CWD'(CORES_PER_NODE)};
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        if (r_ev_vld && fit_take) begin
            n_found     = 1'b1;
            n_pick      = r_ev_idx;
            n_pick_left = fit_left;
            n_pick_c    = fit_cores_rem;
            n_pick_m    = fit_mem_rem;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == IXW'(NODE_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_tag    = s_axis_tdata[7:0];
                    n_need_c = s_axis_tdata[12:8];
                    n_need_m = s_axis_tdata[19:13];
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == IXW'(NODE_COUNT)) begin
                    n_state = ST_DONE;
                end else begin
                    n_ev_vld = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                mem_waddr = r_pick;
                mem_wdata = {r_pick_m, r_pick_c};
                mem_we    = r_found;
                n_out_tag = r_tag;
                if (r_found) begin
                    n_out_placed = 1'b1;
                    n_out_idx    = idx_ext[IDX_OUT_W-1:0];
                    n_out_cores  = cores_ext[CORES_OUT_W-1:0];
                    n_out_mem    = mem_ext[MEM_OUT_W-1:0];
                end else begin
                    n_out_placed = 1'b0;
                    n_out_idx    = '0;
                    n_out_cores  = '0;
                    n_out_mem    = '0;
                end
                n_state = ST_RESP;
            end
            ST_RESP: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_idx      <= '0;
            r_ev_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_fit_mode <= MODE_FIRST;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ev_vld <= n_ev_vld;
            r_found  <= n_found;
            if (i_cfg_we) begin
                r_fit_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx     <= n_ev_idx;
        r_tag        <= n_tag;
        r_need_c     <= n_need_c;
        r_need_m     <= n_need_m;
        r_pick       <= n_pick;
        r_pick_left  <= n_pick_left;
        r_pick_c     <= n_pick_c;
        r_pick_m     <= n_pick_m;
        r_out_tag    <= n_out_tag;
        r_out_placed <= n_out_placed;
        r_out_idx    <= n_out_idx;
        r_out_cores  <= n_out_cores;
        r_out_mem    <= n_out_mem;
    end

    assign m_axis_tdata = {4'b0, r_out_mem, r_out_cores, r_out_idx, r_out_placed, r_out_tag};

endmodule

`default_nettype wire

// ===== rtl/tfa_node_mem.sv =====
// node resource memory: one write port, one registered read port
// depends on nothing
`default_nettype none

module tfa_node_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tfa_fit_unit.sv =====
// shared fit check: compares one node against the request and decides on a take
// depends on tfa_pkg
`default_nettype none

module tfa_fit_unit
    import tfa_pkg::*;
#(
    parameter int CWD = 5,
    parameter int MWD = 7,
    parameter int LW  = 8
) (
    input  wire logic [MODE_W-1:0]   i_mode,
    input  wire logic                i_found,
    input  wire logic [LW-1:0]       i_pick_left,
    input  wire logic [CWD-1:0]      i_cores,
    input  wire logic [MWD-1:0]      i_mem,
    input  wire logic [NEED_C_W-1:0] i_need_c,
    input  wire logic [NEED_M_W-1:0] i_need_m,
    output logic                     o_take,
    output logic [LW-1:0]            o_left,
    output logic [CWD-1:0]           o_cores_rem,
    output logic [MWD-1:0]           o_mem_rem
);

    localparam int CXW = (CWD > NEED_C_W) ? CWD : NEED_C_W;
    localparam int MXW = (MWD > NEED_M_W) ? MWD : NEED_M_W;

    logic [CXW-1:0] cores_x, need_c_x, cores_d;
    logic [MXW-1:0] mem_x, need_m_x, mem_d;
    logic           fits;
    logic           better;

    always_comb begin
        cores_x     = CXW'(i_cores);
        need_c_x    = CXW'(i_need_c);
        mem_x       = MXW'(i_mem);
        need_m_x    = MXW'(i_need_m);
        fits        = (cores_x >= need_c_x) && (mem_x >= need_m_x);
        cores_d     = cores_x - need_c_x;
        mem_d       = mem_x - need_m_x;
        o_left      = LW'(cores_d) + LW'(mem_d);
        o_cores_rem = cores_d[CWD-1:0];
        o_mem_rem   = mem_d[MWD-1:0];
        better      = ((i_mode == MODE_BEST) && (o_left < i_pick_left))
                   || ((i_mode == MODE_WORST) && (o_left > i_pick_left));
        o_take      = fits && (!i_found || better);
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_two_resource_fit_allocator.sv =====
// self-checking testbench for two_resource_fit_allocator: random job traffic with
// stream back-pressure, predicted node choice per fit mode, field-by-field compare
// depends on tfa_pkg and two_resource_fit_allocator
`default_nettype none

module tb_two_resource_fit_allocator;
    import tfa_pkg::*;

    localparam int NODES        = 128;
    localparam int CORES_FULL   = 24;
    localparam int MEM_FULL     = 64;
    localparam int LATENCY      = NODES + 3;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_JOBS   = 120;
    localparam int HOLD_CYCLES  = 600;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [NEED_C_W-1:0] cores;
        logic [NEED_M_W-1:0] mem;
    } job_t;

    typedef struct packed {
        logic [TAG_W-1:0]       tag;
        logic                   placed;
        logic [IDX_OUT_W-1:0]   node;
        logic [CORES_OUT_W-1:0] cores_left;
        logic [MEM_OUT_W-1:0]   mem_left;
    } grant_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [MODE_W-1:0]     i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // node bookkeeping of the predictor
    logic [NEED_C_W-1:0] node_cores [NODES];
    logic [NEED_M_W-1:0] node_mem [NODES];
    logic [MODE_W-1:0]   fit_mode_copy = MODE_FIRST;

    job_t   pending_jobs [$];
    grant_t expected_grants [$];
    int     jobs_pushed = 0;
    int     grants_seen = 0;
    int     error_count = 0;
    bit     no_idle = 1'b0;
    logic   rx_hold = 1'b0;
    logic   s_fire = 1'b0;
    logic   m_fire = 1'b0;
    int     tx_gap = 0;
    int     rx_gap = 0;

    two_resource_fit_allocator #(
        .NODE_COUNT     (NODES),
        .CORES_PER_NODE (CORES_FULL),
        .MEMORY_PER_NODE(MEM_FULL)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),      // fit_mode
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),     // job_tag, cores_needed, memory_needed
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)      // job_tag_out, placed, node_index,
                                          // cores_left, memory_left
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic grant_t fit_and_debit(job_t job);
        grant_t g;
        bit     found;
        int     pick;
        int     pick_left;
        int     left;
        g = '0;
        g.tag = job.tag;
        found = 1'b0;
        pick = 0;
        pick_left = 0;
        for (int n = 0; n < NODES; n++) begin
            if (node_cores[n] >= job.cores && node_mem[n] >= job.mem) begin
                left = int'(node_cores[n] - job.cores) + int'(node_mem[n] - job.mem);
                if (!found) begin
                    found = 1'b1;
                    pick = n;
                    pick_left = left;
                    if (fit_mode_copy != MODE_BEST && fit_mode_copy != MODE_WORST) break;
                end else if (fit_mode_copy == MODE_BEST && left < pick_left) begin
                    pick = n;
                    pick_left = left;
                end else if (fit_mode_copy == MODE_WORST && left > pick_left) begin
                    pick = n;
                    pick_left = left;
                end
            end
        end
        if (found) begin
            node_cores[pick] = node_cores[pick] - job.cores;
            node_mem[pick] = node_mem[pick] - job.mem;
            g.placed = 1'b1;
            g.node = pick[IDX_OUT_W-1:0];
            g.cores_left = node_cores[pick];
            g.mem_left = node_mem[pick];
        end
        return g;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic job_t draw_job();
        job_t j;
        int   r;
        r = $urandom_range(0, 99);
        j.tag = TAG_W'($urandom_range(0, 255));
        if (r < 70) begin
            j.cores = NEED_C_W'($urandom_range(0, 2));
            j.mem = NEED_M_W'($urandom_range(0, 5));
        end else if (r < 90) begin
            j.cores = NEED_C_W'($urandom_range(0, 8));
            j.mem = NEED_M_W'($urandom_range(0, 20));
        end else begin
            j.cores = NEED_C_W'($urandom_range(0, 31));
            j.mem = NEED_M_W'($urandom_range(0, 127));
        end
        return j;
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_jobs.size() != 0) begin
                job_t j;
                j = pending_jobs.pop_front();
                s_axis_tdata <= {{(IN_DATA_W - TAG_W - NEED_C_W - NEED_M_W){1'b0}},
                                 j.mem, j.cores, j.tag};
                s_axis_tvalid <= 1'b1;
                tx_gap = draw_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (m_fire) rx_gap = draw_gap();
        if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !rx_hold;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (grants_seen >= 400);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // monitor: predict on input transaction, compare on output transaction
    always @(posedge i_clk) begin
        s_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        m_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_grants.insert(expected_grants.size(),
                fit_and_debit(job_t'({s_axis_tdata[7:0], s_axis_tdata[12:8],
                                      s_axis_tdata[19:13]})));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            grant_t exp_g;
            grants_seen <= grants_seen + 1;
            if (expected_grants.size() == 0) begin
                $error("unexpected result transaction: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                exp_g = expected_grants.pop_front();
                if (m_axis_tdata[7:0] !== exp_g.tag) begin
                    $error("job_tag_out: expected %0d, actual %0d", exp_g.tag,
                           m_axis_tdata[7:0]);
                    error_count++;
                end
                if (m_axis_tdata[8] !== exp_g.placed) begin
                    $error("placed: expected %0d, actual %0d", exp_g.placed, m_axis_tdata[8]);
                    error_count++;
                end
                if (m_axis_tdata[15:9] !== exp_g.node) begin
                    $error("node_index: expected %0d, actual %0d", exp_g.node,
                           m_axis_tdata[15:9]);
                    error_count++;
                end
                if (m_axis_tdata[20:16] !== exp_g.cores_left) begin
                    $error("cores_left: expected %0d, actual %0d", exp_g.cores_left,
                           m_axis_tdata[20:16]);
                    error_count++;
                end
                if (m_axis_tdata[27:21] !== exp_g.mem_left) begin
                    $error("memory_left: expected %0d, actual %0d", exp_g.mem_left,
                           m_axis_tdata[27:21]);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_job(input logic [TAG_W-1:0] tag, input int cores, input int mem);
        job_t j;
        j.tag = tag;
        j.cores = NEED_C_W'(cores);
        j.mem = NEED_M_W'(mem);
        pending_jobs.insert(pending_jobs.size(), j);
        jobs_pushed++;
    endtask

    // waits until every pushed job has its result back, then sets the mode
    task automatic start_phase(input logic [MODE_W-1:0] mode);
        @(negedge i_clk);
        while (grants_seen < jobs_pushed) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        fit_mode_copy = mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int cycles;
        for (int n = 0; n < NODES; n++) begin
            node_cores[n] = NEED_C_W'(CORES_FULL);
            node_mem[n] = NEED_M_W'(MEM_FULL);
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first fit: no-fit extremes, exact fill, zero needs
        start_phase(MODE_FIRST);
        queue_job(8'd0, 31, 127);
        queue_job(8'd255, 24, 64);
        queue_job(8'd1, 0, 0);
        queue_job(8'd2, 25, 0);
        queue_job(8'd3, 0, 65);
        queue_job(8'd4, 1, 1);
        queue_job(8'd5, 23, 63);

        start_phase(MODE_BEST);
        queue_job(8'd16, 2, 2);
        queue_job(8'd17, 3, 3);
        queue_job(8'd18, 0, 0);
        queue_job(8'd19, 1, 0);
        queue_job(8'd170, 31, 0);

        start_phase(MODE_WORST);
        queue_job(8'd32, 0, 0);
        queue_job(8'd33, 4, 4);
        queue_job(8'd34, 4, 4);
        queue_job(8'd85, 0, 127);

        start_phase(MODE_UNUSED);
        queue_job(8'd48, 5, 5);
        queue_job(8'd49, 0, 0);
        queue_job(8'd50, 31, 0);
        queue_job(8'd51, 24, 0);

        for (int k = 0; k < RAND_PHASES; k++) begin
            start_phase((k < 4) ? k[MODE_W-1:0] : MODE_W'($urandom_range(0, 3)));
            no_idle = (k % 4 == 2);
            for (int i = 0; i < PHASE_JOBS; i++) begin
                pending_jobs.insert(pending_jobs.size(), draw_job());
                jobs_pushed++;
            end
        end

        @(negedge i_clk);
        while (grants_seen < jobs_pushed) @(negedge i_clk);
        cycles = 0;
        while (cycles < LATENCY) begin
            @(negedge i_clk);
            cycles++;
        end
        if (error_count == 0 && expected_grants.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
